### rtl/sctts_pkg.sv
// Shared types and constants for the sorted coordinate toggle set.
`default_nettype none
package sctts_pkg;

	localparam int CAPACITY = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int COORD_W  = 16;

	localparam logic CMD_TOGGLE = 1'b0;
	localparam logic CMD_EMIT   = 1'b1;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_REMOVED  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_ROW_WORD = 2'd3;

	localparam logic [COORD_W-1:0] END_MARKER_RST = 16'h7FFF;

	typedef struct packed {
		logic                      cmd;
		logic signed [COORD_W-1:0] coord;
		logic signed [COORD_W-1:0] row_value;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] word;
		logic [1:0]                status;
		logic                      last;
	} out_word_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_DELETE,
		OP_INSERT,
		OP_ROTATE
	} cell_op_t;

	// Broadcast from the control to every cell.
	typedef struct packed {
		cell_op_t                  op;
		logic signed [COORD_W-1:0] coord;
		logic signed [COORD_W-1:0] head;
	} cell_bcast_t;

	// What a cell shows to its neighbors and to the control.
	typedef struct packed {
		logic signed [COORD_W-1:0] coord;
		logic                      valid;
		logic                      lt;
		logic                      eq;
	} cell_view_t;

endpackage
`default_nettype wire

### rtl/sctts_cell.sv
// One storage cell of the sorted coordinate chain.
`default_nettype none
module sctts_cell
	import sctts_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cell_bcast_t bcast,
	input  wire cell_view_t  left,
	input  wire cell_view_t  right,
	output cell_view_t       view
);

	logic signed [COORD_W-1:0] coord_q;
	logic                      valid_q;

	always_comb begin
		view.coord = coord_q;
		view.valid = valid_q;
		view.lt    = valid_q && (coord_q < bcast.coord);
		view.eq    = valid_q && (coord_q == bcast.coord);
	end

	// Cells at or past the target position move; those before it hold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (bcast.op)
				OP_DELETE: begin
					if (!view.lt) begin
						valid_q <= right.valid;
					end
				end
				OP_INSERT: begin
					if (!view.lt) begin
						valid_q <= left.valid;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (bcast.op)
			OP_DELETE: begin
				if (!view.lt) begin
					coord_q <= right.coord;
				end
			end
			OP_INSERT: begin
				if (!view.lt) begin
					coord_q <= left.lt ? bcast.coord : left.coord;
				end
			end
			OP_ROTATE: begin
				// The last occupied cell takes the head word, closing the ring.
				if (valid_q) begin
					coord_q <= right.valid ? right.coord : bcast.head;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/sorted_coordinate_toggle_set_core.sv
// Top level: sorted coordinate toggle set built from a chain of cells.
// A toggle word appears in the output register in the cycle after acceptance;
// toggles sustain one per unstalled cycle, set by the chain's parallel compare.
// An emit of n > 0 coordinates streams n+1 or n+2 words, one per unstalled
// cycle, by rotating the chain once around (an empty list gives no words); the
// next item is taken after its last word. Reset: empty list, end marker 32767.
`default_nettype none
module sorted_coordinate_toggle_set_core
	import sctts_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_word_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_word_t        out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_COORDS = 3'b010,
		S_END    = 3'b100
	} state_t;

	state_t                    state_q, state_d;
	logic [CNT_W-1:0]          count_q, count_d;
	logic [CNT_W-1:0]          rem_q, rem_d;
	logic [COORD_W-1:0]        end_marker_q;
	logic                      out_valid_q;
	out_word_t                 out_data_q, out_next;
	logic                      load_out;
	logic                      slot_free;
	logic                      in_accept;
	cell_bcast_t               bcast;
	cell_view_t                view  [CAPACITY];
	cell_view_t                left  [CAPACITY];
	cell_view_t                right [CAPACITY];
	logic [CAPACITY-1:0]       eq_vec;
	logic                      present;
	logic                      full;
	logic                      head_is_end;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_marker_q <= END_MARKER_RST;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			end_marker_q <= pwdata[COORD_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (!paddr[2]) begin
			prdata = {{(32 - COORD_W){1'b0}}, end_marker_q};
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_chain
			if (gi == 0) begin : g_first
				// A virtual left neighbor that is occupied and below everything.
				assign left[gi] = '{coord: '0, valid: 1'b1, lt: 1'b1, eq: 1'b0};
			end else begin : g_mid
				assign left[gi] = view[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right[gi] = '{coord: '0, valid: 1'b0, lt: 1'b0, eq: 1'b0};
			end else begin : g_inner
				assign right[gi] = view[gi+1];
			end
			assign eq_vec[gi] = view[gi].eq;

			sctts_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.bcast  (bcast),
				.left   (left[gi]),
				.right  (right[gi]),
				.view   (view[gi])
			);
		end
	endgenerate

	assign present     = |eq_vec;
	assign full        = view[CAPACITY-1].valid;
	assign head_is_end = (view[0].coord == end_marker_q);
	assign slot_free   = !out_valid_q || !out_stall;
	assign in_stall    = !((state_q == S_IDLE) && slot_free);
	assign in_accept   = in_valid && !in_stall;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		rem_d       = rem_q;
		load_out    = 1'b0;
		out_next    = out_data_q;
		bcast.op    = OP_HOLD;
		bcast.coord = in_data.coord;
		bcast.head  = view[0].coord;
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					if (in_data.cmd == CMD_TOGGLE) begin
						load_out = 1'b1;
						if (present) begin
							bcast.op = OP_DELETE;
							count_d  = count_q - 1'b1;
							out_next = '{word: in_data.coord, status: ST_REMOVED, last: 1'b1};
						end else if (full) begin
							out_next = '{word: in_data.coord, status: ST_FULL, last: 1'b1};
						end else begin
							bcast.op = OP_INSERT;
							count_d  = count_q + 1'b1;
							out_next = '{word: in_data.coord, status: ST_INSERTED, last: 1'b1};
						end
					end else if (view[0].valid) begin
						load_out = 1'b1;
						out_next = '{word: in_data.row_value, status: ST_ROW_WORD, last: 1'b0};
						rem_d    = count_q;
						state_d  = S_COORDS;
					end
				end
			end
			S_COORDS: begin
				if (slot_free) begin
					load_out = 1'b1;
					bcast.op = OP_ROTATE;
					rem_d    = rem_q - 1'b1;
					out_next = '{word: view[0].coord, status: ST_ROW_WORD,
						last: (rem_q == CNT_W'(1)) && head_is_end};
					if (rem_q == CNT_W'(1)) begin
						state_d = head_is_end ? S_IDLE : S_END;
					end
				end
			end
			S_END: begin
				if (slot_free) begin
					load_out = 1'b1;
					out_next = '{word: end_marker_q, status: ST_ROW_WORD, last: 1'b1};
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire
